/* src/utf8_validating_decoder_macros.svh */
// Assertion macros shared by the UTF-8 decoder checker.
`ifndef UTF8_VALIDATING_DECODER_MACROS_SVH
`define UTF8_VALIDATING_DECODER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define U8VD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define U8VD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/u8vd_pkg.sv */
// Types, byte-range constants and range check for the UTF-8 decoder.
package u8vd_pkg;

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD3_ED    = 8'hED;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD4_MAX   = 8'hF4;
    localparam logic [7:0] TAIL_MIN    = 8'h80;
    localparam logic [7:0] TAIL_MAX    = 8'hBF;
    localparam logic [7:0] TAIL_E0_MIN = 8'hA0;
    localparam logic [7:0] TAIL_ED_MAX = 8'h9F;
    localparam logic [7:0] TAIL_F0_MIN = 8'h90;
    localparam logic [7:0] TAIL_F4_MAX = 8'h8F;
    localparam logic [7:0] MASK_LEAD2  = 8'h1F;
    localparam logic [7:0] MASK_LEAD3  = 8'h0F;
    localparam logic [7:0] MASK_LEAD4  = 8'h07;
    localparam logic [7:0] MASK_TAIL   = 8'h3F;

    localparam int CP_W  = 21;
    localparam int LEN_W = 3;

    typedef enum logic [2:0] {
        SB_PLAIN = 3'd0,
        SB_E0    = 3'd1,
        SB_ED    = 3'd2,
        SB_F0    = 3'd3,
        SB_F4    = 3'd4
    } sb_class_t;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] char_length;
        logic             error;
        logic             last;
    } result_t;

    function automatic logic second_ok(input logic [7:0] b, input sb_class_t cls);
        logic ok;
        case (cls)
            SB_E0:   ok = (b >= TAIL_E0_MIN) && (b <= TAIL_MAX);
            SB_ED:   ok = (b >= TAIL_MIN) && (b <= TAIL_ED_MAX);
            SB_F0:   ok = (b >= TAIL_F0_MIN) && (b <= TAIL_MAX);
            SB_F4:   ok = (b >= TAIL_MIN) && (b <= TAIL_F4_MAX);
            default: ok = (b >= TAIL_MIN) && (b <= TAIL_MAX);
        endcase
        return ok;
    endfunction

endpackage

/* src/u8vd_core.sv */
// Per-byte grammar check, code point accumulation and decoder state registers.
module u8vd_core
    import u8vd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        end_of_message,
    output logic        res_valid,
    output result_t     res
);

    logic [1:0]      tails_left_reg, tails_left_next;
    sb_class_t       sb_class_reg, sb_class_next;
    logic [2:0]      bytes_seen_reg, bytes_seen_next;
    logic [CP_W-1:0] partial_reg, partial_next;
    logic            discarding_reg, discarding_next;

    sb_class_t       cls_eff;
    logic [CP_W-1:0] partial_shift;
    logic [1:0]      tails_dec;
    logic [2:0]      seen_inc;
    logic            fail;

    assign cls_eff       = (bytes_seen_reg == 3'd1) ? sb_class_reg : SB_PLAIN;
    assign partial_shift = {partial_reg[CP_W-7:0], in_byte[5:0]};
    assign tails_dec     = tails_left_reg - 2'd1;
    assign seen_inc      = bytes_seen_reg + 3'd1;

    always_comb
    begin
        tails_left_next = tails_left_reg;
        sb_class_next   = sb_class_reg;
        bytes_seen_next = bytes_seen_reg;
        partial_next    = partial_reg;
        discarding_next = discarding_reg;
        res_valid       = 1'b0;
        res             = '0;
        res.last        = end_of_message;
        fail            = 1'b0;

        if (discarding_reg)
        begin
            if (end_of_message)
            begin
                discarding_next = 1'b0;
            end
        end
        else if (tails_left_reg == 2'd0)
        begin
            if (in_byte <= ASCII_MAX)
            begin
                res_valid       = 1'b1;
                res.code_point  = CP_W'(in_byte);
                res.char_length = 3'd1;
                bytes_seen_next = 3'd0;
                partial_next    = '0;
                sb_class_next   = SB_PLAIN;
            end
            else if (in_byte >= LEAD2_MIN && in_byte <= LEAD2_MAX)
            begin
                tails_left_next = 2'd1;
                sb_class_next   = SB_PLAIN;
                partial_next    = CP_W'(in_byte & MASK_LEAD2);
                bytes_seen_next = 3'd1;
                fail            = end_of_message;
            end
            else if (in_byte >= LEAD3_MIN && in_byte <= LEAD3_MAX)
            begin
                tails_left_next = 2'd2;
                sb_class_next   = (in_byte == LEAD3_MIN) ? SB_E0 :
                                  (in_byte == LEAD3_ED)  ? SB_ED : SB_PLAIN;
                partial_next    = CP_W'(in_byte & MASK_LEAD3);
                bytes_seen_next = 3'd1;
                fail            = end_of_message;
            end
            else if (in_byte >= LEAD4_MIN && in_byte <= LEAD4_MAX)
            begin
                tails_left_next = 2'd3;
                sb_class_next   = (in_byte == LEAD4_MIN) ? SB_F0 :
                                  (in_byte == LEAD4_MAX) ? SB_F4 : SB_PLAIN;
                partial_next    = CP_W'(in_byte & MASK_LEAD4);
                bytes_seen_next = 3'd1;
                fail            = end_of_message;
            end
            else
            begin
                fail = 1'b1;
            end
        end
        else if (!second_ok(in_byte, cls_eff))
        begin
            fail = 1'b1;
        end
        else if (tails_dec == 2'd0)
        begin
            res_valid       = 1'b1;
            res.code_point  = partial_shift;
            res.char_length = seen_inc;
            tails_left_next = 2'd0;
            sb_class_next   = SB_PLAIN;
            bytes_seen_next = 3'd0;
            partial_next    = '0;
        end
        else
        begin
            tails_left_next = tails_dec;
            bytes_seen_next = seen_inc;
            partial_next    = partial_shift;
            fail            = end_of_message;
        end

        if (fail)
        begin
            tails_left_next = 2'd0;
            sb_class_next   = SB_PLAIN;
            bytes_seen_next = 3'd0;
            partial_next    = '0;
            discarding_next = !end_of_message;
            res_valid       = 1'b1;
            res.code_point  = '0;
            res.char_length = 3'd0;
            res.error       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tails_left_reg <= 2'd0;
            sb_class_reg   <= SB_PLAIN;
            bytes_seen_reg <= 3'd0;
            partial_reg    <= '0;
            discarding_reg <= 1'b0;
        end
        else if (accept)
        begin
            tails_left_reg <= tails_left_next;
            sb_class_reg   <= sb_class_next;
            bytes_seen_reg <= bytes_seen_next;
            partial_reg    <= partial_next;
            discarding_reg <= discarding_next;
        end
    end

endmodule

/* src/u8vd_skid.sv */
// Two-entry output register with skid stage for decoder results.
module u8vd_skid
    import u8vd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    output logic    up_ready,
    input  result_t up_data,
    output logic    down_valid,
    input  logic    down_ready,
    output result_t down_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    up_take;

    assign up_ready   = !skid_valid_reg;
    assign up_take    = up_valid && up_ready;
    assign down_valid = out_valid_reg;
    assign down_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || down_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = up_take;
                out_data_next  = up_data;
            end
        end
        else if (up_take)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = up_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

/* src/utf8_validating_decoder.sv */
// Top level of the strict UTF-8 validating decoder.
// Results are registered in the output register, or the skid register under output stall.
// One byte per cycle while in_ready is high; check and update is one combinational pass.
// Bytes that do not complete a character or raise an error produce no result.
// A two-entry output register holds one extra result while the output is stalled.
// Reset clears the decode state and empties the output register.
module utf8_validating_decoder
    import u8vd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_message,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CP_W-1:0]      code_point,
    output logic [LEN_W-1:0]     char_length,
    output logic                 error,
    output logic                 last
);

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign accept = in_valid && in_ready;

    u8vd_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .in_byte        (in_byte),
        .end_of_message (end_of_message),
        .res_valid      (res_valid),
        .res            (res)
    );

    u8vd_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (accept && res_valid),
        .up_ready   (in_ready),
        .up_data    (res),
        .down_valid (out_valid),
        .down_ready (out_ready),
        .down_data  (out_data)
    );

    assign code_point  = out_data.code_point;
    assign char_length = out_data.char_length;
    assign error       = out_data.error;
    assign last        = out_data.last;

endmodule

/* src/u8vd_checker.sv */
// Port-level assertion checker for the UTF-8 decoder, with its bind.
`include "utf8_validating_decoder_macros.svh"

module u8vd_checker
    import u8vd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [CP_W-1:0]  code_point,
    input logic [LEN_W-1:0] char_length,
    input logic             error,
    input logic             last
);

    `U8VD_ASSERT_NOW(a_error_fields_zero, out_valid && error, code_point == '0 && char_length == '0, "error request carries a code point or length")
    `U8VD_ASSERT_NOW(a_length_range, out_valid && !error, char_length != '0 && char_length <= 3'd4, "character request with length outside 1 to 4")
    `U8VD_ASSERT_NOW(a_single_byte_ascii, out_valid && !error && char_length == 3'd1, code_point[CP_W-1:7] == '0, "single-byte request above 7F")
    `U8VD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(char_length) && $stable(error) && $stable(last), "stalled request changed")

endmodule

bind utf8_validating_decoder u8vd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .char_length (char_length),
    .error       (error),
    .last        (last)
);
